/* rtl/tmcs_pkg.sv */
// Shared constants, types and helper functions of the terminal multiplexer control block.
`default_nettype none

package tmcs_pkg;

  localparam int NUM_LINES  = 16;
  localparam int RING_DEPTH = 16;

  localparam int CMD_W  = 3;
  localparam int WORD_W = 21;
  localparam int LINE_W = 4;
  localparam int CHAR_W = 7;
  localparam int RD_W   = 22;
  localparam int LVL_W  = 3;

  localparam int LINE_IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int RING_PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int ENTRY_W    = LINE_W + CHAR_W;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [CMD_W-1:0] CMD_CTRL_WR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STAT_RD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DATA_WR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DATA_RD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RX_CHAR = 3'd4;
  localparam logic [CMD_W-1:0] CMD_OUT_END = 3'd5;

  localparam logic [2:0] FN_SET_ODONE   = 3'd0;
  localparam logic [2:0] FN_START_OUT   = 3'd1;
  localparam logic [2:0] FN_STOP_IN     = 3'd2;
  localparam logic [2:0] FN_START_IN    = 3'd3;
  localparam logic [2:0] FN_STOP_OUT    = 3'd4;
  localparam logic [2:0] FN_START_OUT_S = 3'd5;
  localparam logic [2:0] FN_STOP_IN_S   = 3'd6;
  localparam logic [2:0] FN_START_IN_S  = 3'd7;

  localparam int BIT_CLR_IN = 3;
  localparam int BIT_MCLR   = 17;
  localparam int BIT_IRQ_EN = 20;
  localparam int FN_LSB     = 6;
  localparam int SEL_LSB    = 12;

  localparam logic [1:0] FLAG_OUT = 2'b01;
  localparam logic [1:0] FLAG_IN  = 2'b10;

  typedef enum logic [2:0] {
    OP_CTRL_WR,
    OP_STAT_RD,
    OP_DATA_WR,
    OP_DATA_RD,
    OP_RX_CHAR,
    OP_OUT_END,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] word;
    logic [LINE_W-1:0] line;
    logic [CHAR_W-1:0] rx_char;
    logic              line_ok;
    logic              sel_ok;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  item;
  } front_t;

  typedef struct packed {
    logic [RD_W-1:0]  read_word;
    logic             irq;
    logic [LVL_W-1:0] irq_level;
  } res_t;

  function automatic logic [RING_PTR_W-1:0] ring_next(input logic [RING_PTR_W-1:0] p);
    return (p == RING_PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic line_in_range(input logic [LINE_W-1:0] l);
    return {1'b0, l} < (LINE_W + 1)'(NUM_LINES);
  endfunction

endpackage

`default_nettype wire

/* rtl/tmcs_front.sv */
// Front end: accepts items, classifies them and holds them in a short queue for the back end.
`default_nettype none

module tmcs_front (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       push_i,
  output logic                      full_o,
  input  wire [tmcs_pkg::CMD_W-1:0] command_i,
  input  wire [tmcs_pkg::WORD_W-1:0] write_word_i,
  input  wire [tmcs_pkg::LINE_W-1:0] line_i,
  input  wire [tmcs_pkg::CHAR_W-1:0] rx_char_i,
  output tmcs_pkg::front_t          front_o,
  input  wire                       take_i
);
  import tmcs_pkg::*;

  op_t                slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  op_t                item;
  logic               push_fire;
  logic               pop_fire;

  always_comb begin
    item.word    = write_word_i;
    item.line    = line_i;
    item.rx_char = rx_char_i;
    item.line_ok = line_in_range(line_i);
    item.sel_ok  = line_in_range(write_word_i[SEL_LSB +: LINE_W]);
    case (command_i)
      CMD_CTRL_WR: item.op = OP_CTRL_WR;
      CMD_STAT_RD: item.op = OP_STAT_RD;
      CMD_DATA_WR: item.op = OP_DATA_WR;
      CMD_DATA_RD: item.op = OP_DATA_RD;
      CMD_RX_CHAR: item.op = OP_RX_CHAR;
      CMD_OUT_END: item.op = OP_OUT_END;
      default:     item.op = OP_NOP;
    endcase
  end

  assign full_o        = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign push_fire     = push_i & ~full_o;
  assign front_o.valid = (cnt_q != '0);
  assign front_o.item  = slot_q[rd_ptr_q];
  assign pop_fire      = front_o.valid & take_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_fire) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_fire && pop_fire) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      slot_q[wr_ptr_q] <= item;
    end
  end

endmodule

`default_nettype wire

/* rtl/tmcs_back.sv */
// Back end: applies items to the line flags, status word and receive ring, and queues results.
`default_nettype none

module tmcs_back (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire tmcs_pkg::front_t      front_i,
  output logic                       take_o,
  output logic                       empty_o,
  input  wire                        pop_i,
  output logic [tmcs_pkg::RD_W-1:0]  read_word_o,
  output logic                       irq_o,
  output logic [tmcs_pkg::LVL_W-1:0] irq_level_o
);
  import tmcs_pkg::*;

  logic [LVL_W-1:0]      chan_q, chan_d;
  logic                  in_done_q, in_done_d;
  logic                  out_done_q, out_done_d;
  logic [LINE_W-1:0]     fin_q, fin_d;
  logic                  irq_en_q, irq_en_d;
  logic [1:0]            flags_q [NUM_LINES];
  logic [1:0]            flags_d [NUM_LINES];
  logic [RING_PTR_W-1:0] rp_q, rp_d;
  logic [RING_PTR_W-1:0] wp_q, wp_d;
  logic [ENTRY_W-1:0]    ring_q [RING_DEPTH];
  logic                  ring_we;
  logic [ENTRY_W-1:0]    ring_rd;
  logic [RING_PTR_W-1:0] rp_nx;

  res_t                  res_slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]    res_wr_q, res_rd_q;
  logic [Q_CNT_W-1:0]    res_cnt_q, res_cnt_d;
  res_t                  res;
  logic                  fire;
  logic                  pop_fire;

  logic [1:0]            setf, clrf;
  logic [LINE_IDX_W-1:0] sel_idx, line_idx;
  op_t                   it;

  assign it       = front_i.item;
  assign sel_idx  = it.word[SEL_LSB +: LINE_IDX_W];
  assign line_idx = it.line[LINE_IDX_W-1:0];
  assign ring_rd  = ring_q[rp_q];
  assign rp_nx    = ring_next(rp_q);

  assign take_o   = (res_cnt_q != Q_CNT_W'(Q_DEPTH));
  assign fire     = front_i.valid & take_o;
  assign empty_o  = (res_cnt_q == '0);
  assign pop_fire = pop_i & ~empty_o;

  always_comb begin
    chan_d        = chan_q;
    in_done_d     = in_done_q;
    out_done_d    = out_done_q;
    fin_d         = fin_q;
    irq_en_d      = irq_en_q;
    flags_d       = flags_q;
    rp_d          = rp_q;
    wp_d          = wp_q;
    ring_we       = 1'b0;
    setf          = '0;
    clrf          = '0;
    res.read_word = '0;
    if (fire) begin
      case (it.op)
        OP_CTRL_WR: begin
          if (it.word[BIT_MCLR]) begin
            chan_d     = '0;
            in_done_d  = 1'b0;
            out_done_d = 1'b0;
            fin_d      = '0;
            irq_en_d   = 1'b0;
            for (int i = 0; i < NUM_LINES; i++) begin
              flags_d[i] = '0;
            end
            rp_d = '0;
            wp_d = '0;
          end
          if (it.word[BIT_CLR_IN]) begin
            in_done_d = 1'b0;
            rp_d      = '0;
            wp_d      = '0;
          end
          case (it.word[FN_LSB +: 3])
            FN_SET_ODONE: out_done_d = 1'b1;
            FN_START_OUT: begin
              setf       = FLAG_OUT;
              out_done_d = 1'b0;
            end
            FN_STOP_IN:  clrf = FLAG_IN;
            FN_START_IN: setf = FLAG_IN;
            FN_STOP_OUT: begin
              clrf       = FLAG_OUT;
              out_done_d = 1'b0;
            end
            FN_START_OUT_S: setf = FLAG_OUT;
            FN_STOP_IN_S:   clrf = FLAG_IN;
            FN_START_IN_S:  setf = FLAG_IN;
            default:        setf = FLAG_IN;
          endcase
          if (it.sel_ok) begin
            flags_d[sel_idx] = (flags_d[sel_idx] | setf) & ~clrf;
          end
          chan_d = it.word[LVL_W-1:0];
        end
        OP_STAT_RD: begin
          res.read_word = {fin_q, 9'b0, out_done_q, 4'b0, in_done_q, chan_q};
        end
        OP_DATA_WR: begin
          if (it.word[BIT_IRQ_EN]) begin
            irq_en_d = 1'b1;
          end
        end
        OP_DATA_RD: begin
          if (rp_q != wp_q) begin
            res.read_word = {ring_rd[ENTRY_W-1 -: LINE_W], 11'b0, ring_rd[CHAR_W-1:0]};
            rp_d = rp_nx;
            if (rp_nx == wp_q) begin
              in_done_d = 1'b0;
            end
          end
        end
        OP_RX_CHAR: begin
          if (it.line_ok && ((flags_q[line_idx] & FLAG_IN) != '0)) begin
            ring_we   = 1'b1;
            wp_d      = ring_next(wp_q);
            in_done_d = 1'b1;
          end
        end
        OP_OUT_END: begin
          if (it.line_ok && ((flags_q[line_idx] & FLAG_OUT) != '0)) begin
            flags_d[line_idx] = flags_q[line_idx] & ~FLAG_OUT;
            fin_d             = it.line;
            out_done_d        = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    res.irq       = irq_en_d & (in_done_d | out_done_d);
    res.irq_level = res.irq ? chan_d : '0;
  end

  always_comb begin
    res_cnt_d = res_cnt_q;
    if (fire && !pop_fire) begin
      res_cnt_d = res_cnt_q + 1'b1;
    end else if (!fire && pop_fire) begin
      res_cnt_d = res_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q     <= '0;
      in_done_q  <= 1'b0;
      out_done_q <= 1'b0;
      fin_q      <= '0;
      irq_en_q   <= 1'b0;
      for (int i = 0; i < NUM_LINES; i++) begin
        flags_q[i] <= '0;
      end
      rp_q      <= '0;
      wp_q      <= '0;
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      chan_q     <= chan_d;
      in_done_q  <= in_done_d;
      out_done_q <= out_done_d;
      fin_q      <= fin_d;
      irq_en_q   <= irq_en_d;
      flags_q    <= flags_d;
      rp_q       <= rp_d;
      wp_q       <= wp_d;
      res_cnt_q  <= res_cnt_d;
      if (fire) begin
        res_wr_q <= res_wr_q + 1'b1;
      end
      if (pop_fire) begin
        res_rd_q <= res_rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[wp_q] <= {it.line, it.rx_char};
    end
    if (fire) begin
      res_slot_q[res_wr_q] <= res;
    end
  end

  assign read_word_o = res_slot_q[res_rd_q].read_word;
  assign irq_o       = res_slot_q[res_rd_q].irq;
  assign irq_level_o = res_slot_q[res_rd_q].irq_level;

endmodule

`default_nettype wire

/* rtl/terminal_mux_control_status.sv */
// Top level of the terminal multiplexer control and status block.
// Items enter through a queue-style port: an item transfers at a rising
// edge where push_i is high and full_o is low. Each item is a control
// write, status read, data write, data read, received character or
// output-end event, and it yields exactly one result.
// Results leave through a second queue-style port: while empty_o is low
// the oldest result is on read_word_o, irq_o and irq_level_o, and it
// transfers at a rising edge where pop_i is high.
// An item transferred at an input edge is registered in the front queue;
// the back end applies it once it heads that queue and the result queue
// has room, and registers its result there. One item per cycle is
// sustained while results drain, set by the back end's single state update.
// A two-entry queue sits between the front and back ends and another
// holds results. When the receiver stalls, up to two results wait, then
// the back end stops and the front queue fills; full_o rises after two
// more items.
// Reset clears the status word, line flags, interrupt enable and ring
// pointers; the receive ring contents are not cleared, and only entries
// written since are ever read.
`default_nettype none

module terminal_mux_control_status (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         push_i,
  output logic                        full_o,
  input  wire [tmcs_pkg::CMD_W-1:0]   command_i,
  input  wire [tmcs_pkg::WORD_W-1:0]  write_word_i,
  input  wire [tmcs_pkg::LINE_W-1:0]  line_i,
  input  wire [tmcs_pkg::CHAR_W-1:0]  rx_char_i,
  output logic                        empty_o,
  input  wire                         pop_i,
  output logic [tmcs_pkg::RD_W-1:0]   read_word_o,
  output logic                        irq_o,
  output logic [tmcs_pkg::LVL_W-1:0]  irq_level_o
);
  import tmcs_pkg::*;

  front_t front;
  logic   take;

  tmcs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .command_i    (command_i),
    .write_word_i (write_word_i),
    .line_i       (line_i),
    .rx_char_i    (rx_char_i),
    .front_o      (front),
    .take_i       (take)
  );

  tmcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .front_i     (front),
    .take_o      (take),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .read_word_o (read_word_o),
    .irq_o       (irq_o),
    .irq_level_o (irq_level_o)
  );

endmodule

`default_nettype wire

/* rtl/tmcs_checker.sv */
// Port-level checker of the terminal multiplexer control block and its binding.
`default_nettype none

module tmcs_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        push_i,
  input wire        full_o,
  input wire [2:0]  command_i,
  input wire [20:0] write_word_i,
  input wire [3:0]  line_i,
  input wire [6:0]  rx_char_i,
  input wire        empty_o,
  input wire        pop_i,
  input wire [21:0] read_word_o,
  input wire        irq_o,
  input wire [2:0]  irq_level_o
);

  a_level_without_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !irq_o) |-> (irq_level_o == 3'd0))
    else $error("Interrupt level is nonzero without a request.");

  a_unused_read_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (read_word_o[17:9] == 9'd0))
    else $error("Read data has bits set that no command produces.");

  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!full_o && !push_i) |=> !full_o)
    else $error("Input side became full without a transfer.");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(read_word_o) && $stable(irq_o)
                              && $stable(irq_level_o)))
    else $error("Waiting result changed before its transfer.");

endmodule

bind terminal_mux_control_status tmcs_checker u_tmcs_checker (.*);

`default_nettype wire

/* dv/terminal_mux_control_status_tb.sv */
// Self-checking testbench: random bus and line-event transfers scored against a built-in status model.
`default_nettype none

module terminal_mux_control_status_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmcs_pkg::*;

  localparam int INDONE_BIT     = 3;
  localparam int ODONE_BIT      = 8;
  localparam int FIN_LINE_LSB   = 18;
  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 1350;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int CYCLE_LIMIT    = 200000;

  class mux_status_board;
    logic [LVL_W-1:0]   chan;
    logic               in_done;
    logic               out_done;
    logic [LINE_W-1:0]  fin_line;
    logic               irq_en;
    logic [1:0]         flags [NUM_LINES];
    logic [ENTRY_W-1:0] ring [RING_DEPTH];
    int                 rd_ptr;
    int                 wr_ptr;
    res_t               expected_replies [$];
    int                 mismatches;

    function void clear_all();
      chan     = '0;
      in_done  = 1'b0;
      out_done = 1'b0;
      fin_line = '0;
      irq_en   = 1'b0;
      rd_ptr   = 0;
      wr_ptr   = 0;
      foreach (flags[i]) flags[i] = '0;
    endfunction

    function void note_transfer(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] w,
                                logic [LINE_W-1:0] ln, logic [CHAR_W-1:0] ch);
      res_t               reply;
      logic [1:0]         setf;
      logic [1:0]         clrf;
      logic [LINE_W-1:0]  sel;
      logic [ENTRY_W-1:0] e;
      reply = '0;
      setf  = '0;
      clrf  = '0;
      case (cmd)
        CMD_CTRL_WR: begin
          if (w[BIT_MCLR]) clear_all();
          if (w[BIT_CLR_IN]) begin
            in_done = 1'b0;
            rd_ptr  = 0;
            wr_ptr  = 0;
          end
          case (w[FN_LSB +: 3])
            FN_SET_ODONE: out_done = 1'b1;
            FN_START_OUT: begin
              setf     = FLAG_OUT;
              out_done = 1'b0;
            end
            FN_STOP_IN, FN_STOP_IN_S: clrf = FLAG_IN;
            FN_START_IN, FN_START_IN_S: setf = FLAG_IN;
            FN_STOP_OUT: begin
              clrf     = FLAG_OUT;
              out_done = 1'b0;
            end
            default: setf = FLAG_OUT;
          endcase
          sel = w[SEL_LSB +: LINE_W];
          if (int'(sel) < NUM_LINES) flags[sel] = (flags[sel] | setf) & ~clrf;
          chan = w[LVL_W-1:0];
        end
        CMD_STAT_RD: begin
          reply.read_word = RD_W'(chan);
          reply.read_word[INDONE_BIT] = in_done;
          reply.read_word[ODONE_BIT]  = out_done;
          reply.read_word[FIN_LINE_LSB +: LINE_W] = fin_line;
        end
        CMD_DATA_WR: begin
          if (w[BIT_IRQ_EN]) irq_en = 1'b1;
        end
        CMD_DATA_RD: begin
          if (rd_ptr != wr_ptr) begin
            e = ring[rd_ptr];
            reply.read_word[FIN_LINE_LSB +: LINE_W] = e[CHAR_W +: LINE_W];
            reply.read_word[CHAR_W-1:0] = e[CHAR_W-1:0];
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            if (rd_ptr == wr_ptr) in_done = 1'b0;
          end
        end
        CMD_RX_CHAR: begin
          if (int'(ln) < NUM_LINES && (flags[ln] & FLAG_IN) != '0) begin
            ring[wr_ptr] = {ln, ch};
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            in_done = 1'b1;
          end
        end
        CMD_OUT_END: begin
          if (int'(ln) < NUM_LINES && (flags[ln] & FLAG_OUT) != '0) begin
            flags[ln] = flags[ln] & ~FLAG_OUT;
            fin_line  = ln;
            out_done  = 1'b1;
          end
        end
        default: ;
      endcase
      reply.irq       = irq_en && (in_done || out_done);
      reply.irq_level = reply.irq ? chan : '0;
      expected_replies.push_back(reply);
    endfunction

    function void check_result(logic [RD_W-1:0] rd, logic irq, logic [LVL_W-1:0] lvl);
      res_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: read_word=%h irq=%b level=%0d",
                   $realtime, rd, irq, lvl);
      end else begin
        want = expected_replies.pop_front();
        if (rd !== want.read_word || irq !== want.irq || lvl !== want.irq_level) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected read_word=%h irq=%b level=%0d, got %h %b %0d",
                     $realtime, want.read_word, want.irq, want.irq_level, rd, irq, lvl);
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               push_i;
  logic               full_o;
  logic [CMD_W-1:0]   command_i;
  logic [WORD_W-1:0]  write_word_i;
  logic [LINE_W-1:0]  line_i;
  logic [CHAR_W-1:0]  rx_char_i;
  logic               empty_o;
  logic               pop_i;
  logic [RD_W-1:0]    read_word_o;
  logic               irq_o;
  logic [LVL_W-1:0]   irq_level_o;

  mux_status_board board;
  int              cycles;
  int              items_sent;
  int              burst_left;

  terminal_mux_control_status u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .command_i    (command_i),
    .write_word_i (write_word_i),
    .line_i       (line_i),
    .rx_char_i    (rx_char_i),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .read_word_o  (read_word_o),
    .irq_o        (irq_o),
    .irq_level_o  (irq_level_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni) begin
      if (push_i && !full_o) board.note_transfer(command_i, write_word_i, line_i, rx_char_i);
      if (pop_i && !empty_o) board.check_result(read_word_o, irq_o, irq_level_o);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("terminal_mux_control_status verification failed");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return WORD_W'($urandom);
  endfunction

  function automatic logic [LINE_W-1:0] pick_line();
    return ($urandom_range(0, 3) != 0) ? LINE_W'($urandom_range(0, 3))
                                       : LINE_W'($urandom_range(0, NUM_LINES - 1));
  endfunction

  function automatic logic [WORD_W-1:0] ctrl_word(logic [LVL_W-1:0] chan, logic clr,
                                                  logic [2:0] fn, logic [LINE_W-1:0] sel,
                                                  logic mclr);
    logic [WORD_W-1:0] w;
    w = rand_word();
    w[LVL_W-1:0]          = chan;
    w[BIT_CLR_IN]         = clr;
    w[FN_LSB +: 3]        = fn;
    w[SEL_LSB +: LINE_W]  = sel;
    w[BIT_MCLR]           = mclr;
    return w;
  endfunction

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] w,
                           logic [LINE_W-1:0] ln, logic [CHAR_W-1:0] ch);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk_i);
        push_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    push_i       <= 1'b1;
    command_i    <= cmd;
    write_word_i <= w;
    line_i       <= ln;
    rx_char_i    <= ch;
    forever begin
      @(posedge clk_i);
      if (!full_o) break;
    end
    items_sent++;
  endtask

  task automatic send_ctrl(logic [LVL_W-1:0] chan, logic clr, logic [2:0] fn,
                           logic [LINE_W-1:0] sel, logic mclr);
    send_item(CMD_CTRL_WR, ctrl_word(chan, clr, fn, sel, mclr), LINE_W'($urandom),
              CHAR_W'($urandom));
  endtask

  task automatic send_plain(logic [CMD_W-1:0] cmd);
    send_item(cmd, rand_word(), LINE_W'($urandom), CHAR_W'($urandom));
  endtask

  task automatic send_event(logic [CMD_W-1:0] cmd, logic [LINE_W-1:0] ln,
                            logic [CHAR_W-1:0] ch);
    send_item(cmd, rand_word(), ln, ch);
  endtask

  // The receiver switches among stall styles and once holds off long enough to back up the input.
  initial begin
    int         mode;
    int         mode_left;
    logic [7:0] stall_pattern;
    bit         held;
    mode      = 0;
    mode_left = 0;
    held      = 1'b0;
    stall_pattern = 8'hff;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && items_sent >= 500) begin
        held = 1'b1;
        pop_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode          = $urandom_range(0, 3);
          mode_left     = $urandom_range(16, 96);
          stall_pattern = 8'($urandom) | 8'h01;
        end
        mode_left--;
        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        case (mode)
          0: pop_i <= 1'b1;
          1: pop_i <= 1'($urandom);
          2: pop_i <= stall_pattern[0];
          default: pop_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    logic [2:0] fn_on [4];
    int         n;
    logic [WORD_W-1:0] w;
    fn_on = '{FN_START_IN, FN_START_IN_S, FN_START_OUT, FN_START_OUT_S};
    board        = new();
    board.clear_all();
    cycles       = 0;
    items_sent   = 0;
    burst_left   = 0;
    rst_ni       = 1'b0;
    push_i       = 1'b0;
    pop_i        = 1'b0;
    command_i    = '0;
    write_word_i = '0;
    line_i       = '0;
    rx_char_i    = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_plain(CMD_STAT_RD);
    send_plain(CMD_DATA_RD);
    send_item(CMD_CTRL_WR, '0, '0, '0);
    send_item(CMD_CTRL_WR, '1, '1, '1);
    send_ctrl(3'd3, 1'b0, FN_START_OUT, 4'd15, 1'b0);
    send_item(CMD_DATA_WR, '1, '0, '1);
    send_event(CMD_RX_CHAR, 4'd15, 7'h7f);
    send_event(CMD_RX_CHAR, 4'd0, 7'h00);
    send_event(CMD_OUT_END, 4'd0, 7'h00);
    send_event(CMD_OUT_END, 4'd15, 7'h2a);
    send_plain(CMD_STAT_RD);
    send_plain(CMD_DATA_RD);
    send_plain(CMD_DATA_RD);
    send_ctrl(3'd6, 1'b0, FN_STOP_IN_S, 4'd15, 1'b0);
    send_event(CMD_RX_CHAR, 4'd15, 7'h11);
    send_ctrl(3'd1, 1'b0, FN_START_IN, 4'd0, 1'b0);
    send_event(CMD_RX_CHAR, 4'd0, 7'h55);
    send_ctrl(3'd2, 1'b1, FN_STOP_IN, 4'd0, 1'b0);
    send_plain(CMD_DATA_RD);
    send_ctrl(3'd4, 1'b0, FN_SET_ODONE, 4'd0, 1'b0);
    send_ctrl(3'd5, 1'b0, FN_STOP_OUT, 4'd15, 1'b0);
    send_plain(CMD_STAT_RD);
    send_ctrl(3'd7, 1'b0, FN_START_OUT_S, 4'd2, 1'b1);
    send_item(CMD_DATA_WR, '0, '1, '0);
    send_plain(CMD_STAT_RD);

    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 3))
            send_ctrl(LVL_W'($urandom), 1'b0, fn_on[$urandom_range(0, 3)], pick_line(), 1'b0);
        end
        2, 3: begin
          repeat ($urandom_range(1, 20))
            send_event(CMD_RX_CHAR, pick_line(), CHAR_W'($urandom));
        end
        4, 5: begin
          repeat ($urandom_range(1, 18)) send_plain(CMD_DATA_RD);
          send_plain(CMD_STAT_RD);
        end
        6: begin
          repeat ($urandom_range(1, 4)) send_event(CMD_OUT_END, pick_line(), CHAR_W'($urandom));
          send_plain(CMD_STAT_RD);
        end
        7: begin
          send_plain(CMD_DATA_WR);
          send_plain(CMD_STAT_RD);
        end
        8: begin
          send_ctrl(LVL_W'($urandom), ($urandom_range(0, 3) == 0), 3'($urandom), pick_line(),
                    ($urandom_range(0, 15) == 0));
        end
        default: begin
          n = $urandom_range(1, 6);
          repeat (n) begin
            w = rand_word();
            if ($urandom_range(0, 7) != 0) w[BIT_MCLR] = 1'b0;
            send_item(CMD_W'($urandom_range(CMD_CTRL_WR, CMD_OUT_END)), w,
                      LINE_W'($urandom), CHAR_W'($urandom));
          end
        end
      endcase
    end

    @(negedge clk_i);
    push_i <= 1'b0;
    while (board.expected_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_replies.size() == 0) begin
      $display("terminal_mux_control_status verification clean");
    end else begin
      $display("terminal_mux_control_status verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/tmcs_pkg.sv
rtl/tmcs_front.sv
rtl/tmcs_back.sv
rtl/terminal_mux_control_status.sv
rtl/tmcs_checker.sv
dv/terminal_mux_control_status_tb.sv
